[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL, all reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[rtl/core/i2cs_pkg.sv]
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types and constants of the I2C slave byte engine.
// ----------------------------------------------------------------------------
package i2cs_pkg;

    localparam int RECV_DEPTH  = 16;
    localparam int SEND_DEPTH  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ADDR_MASK = 8'hfe;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDR = 2'd0;
    localparam logic [1:0] CFG_SEND_LEN = 2'd1;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_SHIFT = 2'd2,
        FUNC_LOAD  = 2'd3
    } t_func;

    // classified bus event, front to back
    typedef struct packed {
        t_func      func;
        logic [7:0] shift_value;
        logic [3:0] load_index;
        logic [7:0] load_data;
        logic       load_ok;
    } t_cmd;

endpackage

[rtl/core/i2cs_ram.sv]
// ----------------------------------------------------------------------------
// i2cs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/i2cs_front.sv]
// ----------------------------------------------------------------------------
// i2cs_front
// Accepts bus events, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
module i2cs_front #(
    parameter int SEND_DEPTH = i2cs_pkg::SEND_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_func,
    input  logic [7:0]     i_shift_value,
    input  logic [3:0]     i_load_index,
    input  logic [7:0]     i_load_data,
    output logic           o_cmd_valid,
    output i2cs_pkg::t_cmd o_cmd,
    input  logic           i_cmd_pop
);

    localparam int PW = $clog2(i2cs_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(i2cs_pkg::QUEUE_DEPTH + 1);

    i2cs_pkg::t_cmd r_queue [i2cs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    i2cs_pkg::t_cmd cmd_in;
    logic           push;
    logic           pop;

    // loads beyond the store are dropped by the sequencer
    always_comb begin
        cmd_in.func        = i2cs_pkg::t_func'(i_func);
        cmd_in.shift_value = i_shift_value;
        cmd_in.load_index  = i_load_index;
        cmd_in.load_data   = i_load_data;
        cmd_in.load_ok     = ({4'b0, i_load_index} < 8'(SEND_DEPTH));
    end

    assign o_in_stall  = (r_count == CW'(i2cs_pkg::QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && (r_count != '0);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(i2cs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(i2cs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[rtl/core/i2cs_back.sv]
// ----------------------------------------------------------------------------
// i2cs_back
// Byte sequencer: executes queued events, owns the send store and result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cs_back #(
    parameter int RECV_DEPTH = i2cs_pkg::RECV_DEPTH,
    parameter int SEND_DEPTH = i2cs_pkg::SEND_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  i2cs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_sda_drive,
    output logic [7:0]     o_tx_byte,
    output logic [3:0]     o_shift_bits,
    output logic           o_listen_overflow,
    output logic           o_rx_valid,
    output logic [7:0]     o_rx_byte,
    output logic           o_rx_done,
    output logic [4:0]     o_rx_count
);

    localparam int RW = $clog2(RECV_DEPTH + 1);
    localparam int AW = $clog2(SEND_DEPTH > 1 ? SEND_DEPTH : 2);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_RECV_ACKED,
        PH_RECV_DATA,
        PH_SEND_CHECK,
        PH_SEND,
        PH_SEND_GET_ACK
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [RW-1:0] r_recv_count, n_recv_count;
    logic [4:0]  r_send_index, n_send_index;
    logic [7:0]  r_own_addr, n_own_addr;
    logic [4:0]  r_send_len, n_send_len;
    // held bus setup; r_tx_ram means the held byte sits in the RAM read port
    logic        r_drive, n_drive;
    logic [7:0]  r_tx, n_tx;
    logic        r_tx_ram, n_tx_ram;
    logic [3:0]  r_bits, n_bits;
    logic        r_listen, n_listen;
    // result register
    logic        r_out_valid, n_out_valid;
    logic        r_o_drive, r_o_tx_ram, r_o_listen, r_o_rx_valid, r_o_rx_done;
    logic [7:0]  r_o_tx, r_o_rx_byte;
    logic [3:0]  r_o_bits;
    logic [4:0]  r_o_rx_count;
    logic        rx_valid, rx_done;
    logic [7:0]  rx_byte;
    logic [RW-1:0] rx_cnt;
    logic [RW-1:0] recv_inc;
    logic [RW+4:0] rx_cnt_wide;
    logic [7:0]  len_clamp;
    logic        pop;
    logic        ram_we, ram_re;
    logic [AW+3:0] waddr_wide;
    logic [AW+4:0] raddr_wide;
    logic [7:0]  ram_rdata;

    assign pop       = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_pop = pop;
    assign len_clamp = ({3'b0, r_send_len} < 8'(SEND_DEPTH)) ? {3'b0, r_send_len}
                                                            : 8'(SEND_DEPTH);
    assign recv_inc  = r_recv_count + 1'b1;
    assign waddr_wide = {{AW{1'b0}}, i_cmd.load_index};
    assign raddr_wide = {{AW{1'b0}}, r_send_index};

    always_comb begin
        n_phase      = r_phase;
        n_recv_count = r_recv_count;
        n_send_index = r_send_index;
        n_own_addr   = r_own_addr;
        n_send_len   = r_send_len;
        n_drive      = r_drive;
        n_tx         = r_tx;
        n_tx_ram     = r_tx_ram;
        n_bits       = r_bits;
        n_listen     = r_listen;
        rx_valid     = 1'b0;
        rx_byte      = 8'd0;
        rx_done      = 1'b0;
        rx_cnt       = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                i2cs_pkg::CFG_OWN_ADDR: n_own_addr = i_cfg_data;
                i2cs_pkg::CFG_SEND_LEN: n_send_len = i_cfg_data[4:0];
                default: ;
            endcase
        end

        if (pop) begin
            case (i_cmd.func)
                i2cs_pkg::FUNC_START: begin
                    n_phase = PH_ADDR;
                    {n_drive, n_tx, n_tx_ram, n_bits, n_listen} = {1'b0, 8'd0, 1'b0, 4'd8, 1'b1};
                end
                i2cs_pkg::FUNC_STOP: begin
                    if (r_phase == PH_RECV_DATA) begin
                        rx_done = 1'b1;
                        rx_cnt  = r_recv_count;
                        n_phase = PH_IDLE;
                        {n_drive, n_tx, n_tx_ram, n_bits, n_listen} = '0;
                    end
                end
                i2cs_pkg::FUNC_LOAD: begin
                    ram_we = i_cmd.load_ok;
                end
                default: begin
                    case (r_phase)
                        PH_ADDR: begin
                            if ((i_cmd.shift_value & i2cs_pkg::ADDR_MASK) == r_own_addr) begin
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} =
                                    {1'b1, 8'd0, 1'b0, 4'd1, 1'b1};
                                if (i_cmd.shift_value[0]) begin
                                    n_send_index = '0;
                                    n_phase      = PH_SEND;
                                end else begin
                                    n_recv_count = '0;
                                    n_phase      = PH_RECV_ACKED;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} = '0;
                            end
                        end
                        PH_RECV_ACKED: begin
                            {n_drive, n_tx, n_tx_ram, n_bits, n_listen} =
                                {1'b0, 8'd0, 1'b0, 4'd8, 1'b1};
                            n_phase = PH_RECV_DATA;
                        end
                        PH_RECV_DATA: begin
                            rx_valid     = 1'b1;
                            rx_byte      = i_cmd.shift_value;
                            n_recv_count = recv_inc;
                            if (recv_inc < RW'(RECV_DEPTH)) begin
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} =
                                    {1'b1, 8'd0, 1'b0, 4'd1, 1'b1};
                                n_phase = PH_RECV_ACKED;
                            end else begin
                                rx_done = 1'b1;
                                rx_cnt  = recv_inc;
                                n_phase = PH_IDLE;
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} = '0;
                            end
                        end
                        PH_SEND, PH_SEND_CHECK: begin
                            // any nonzero acknowledge sample is a master NACK
                            if (r_phase == PH_SEND_CHECK && i_cmd.shift_value != 8'd0) begin
                                n_phase = PH_IDLE;
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} = '0;
                            end else if ({3'b0, r_send_index} < len_clamp) begin
                                ram_re       = 1'b1;
                                n_send_index = r_send_index + 1'b1;
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} =
                                    {1'b1, 8'd0, 1'b1, 4'd8, 1'b1};
                                n_phase = PH_SEND_GET_ACK;
                            end else begin
                                n_phase = PH_IDLE;
                                {n_drive, n_tx, n_tx_ram, n_bits, n_listen} = '0;
                            end
                        end
                        PH_SEND_GET_ACK: begin
                            {n_drive, n_tx, n_tx_ram, n_bits, n_listen} =
                                {1'b0, 8'd0, 1'b0, 4'd1, 1'b1};
                            n_phase = PH_SEND_CHECK;
                        end
                        default: ;
                    endcase
                end
            endcase
        end

        if (pop) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    assign rx_cnt_wide = {5'b0, rx_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_recv_count <= '0;
            r_send_index <= '0;
            r_own_addr   <= '0;
            r_send_len   <= '0;
            r_drive      <= 1'b0;
            r_tx         <= '0;
            r_tx_ram     <= 1'b0;
            r_bits       <= '0;
            r_listen     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_recv_count <= n_recv_count;
            r_send_index <= n_send_index;
            r_own_addr   <= n_own_addr;
            r_send_len   <= n_send_len;
            r_drive      <= n_drive;
            r_tx         <= n_tx;
            r_tx_ram     <= n_tx_ram;
            r_bits       <= n_bits;
            r_listen     <= n_listen;
            r_out_valid  <= n_out_valid;
        end
        if (pop) begin
            r_o_drive    <= n_drive;
            r_o_tx       <= n_tx;
            r_o_tx_ram   <= n_tx_ram;
            r_o_bits     <= n_bits;
            r_o_listen   <= n_listen;
            r_o_rx_valid <= rx_valid;
            r_o_rx_byte  <= rx_byte;
            r_o_rx_done  <= rx_done;
            r_o_rx_count <= rx_cnt_wide[4:0];
        end
    end

    i2cs_ram #(
        .WIDTH (8),
        .DEPTH (SEND_DEPTH)
    ) u_send_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_wide[AW-1:0]),
        .i_wdata (i_cmd.load_data),
        .i_re    (ram_re),
        .i_raddr (raddr_wide[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // the RAM read port keeps the last sent byte until the next read
    assign o_out_valid       = r_out_valid;
    assign o_sda_drive       = r_o_drive;
    assign o_tx_byte         = r_o_tx_ram ? ram_rdata : r_o_tx;
    assign o_shift_bits      = r_o_bits;
    assign o_listen_overflow = r_o_listen;
    assign o_rx_valid        = r_o_rx_valid;
    assign o_rx_byte         = r_o_rx_byte;
    assign o_rx_done         = r_o_rx_done;
    assign o_rx_count        = r_o_rx_count;

    `ASSERT_AT(a_idle_released, i_clk, i_rst_n, (r_phase == PH_IDLE) |-> (r_bits == 4'd0 && !r_listen && !r_drive))
    `ASSERT_AT(a_read_in_send, i_clk, i_rst_n, ram_re |-> (r_phase == PH_SEND || r_phase == PH_SEND_CHECK))
    `ASSERT_NEVER(a_recv_bound, i_clk, i_rst_n, r_recv_count > RW'(RECV_DEPTH))
    `ASSERT_AT(a_done_goes_idle, i_clk, i_rst_n, (r_out_valid && r_o_rx_done) |-> (r_o_bits == 4'd0 && !r_o_drive))

endmodule

[rtl/core/i2c_slave_byte_engine.sv]
// ----------------------------------------------------------------------------
// i2c_slave_byte_engine
// I2C slave byte sequencer: event queue in front, sequencer and send store
// behind it.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | i_in_valid / o_in_stall | func, shift_value, load_index/data
//  out     | o_out_valid/i_out_stall | bus setup, rx byte, rx frame end
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled.
// Each event is registered in the event queue, then in the result register.
// A stalled output holds the sequencer; the queue fills to its two entries,
// then the input stalls. Synchronous reset; no clearing pass: send entries
// must be loaded by the user before read; the block does not enforce it.
// Configuration is always ready and takes effect at the next edge.
// ----------------------------------------------------------------------------
module i2c_slave_byte_engine #(
    parameter int RECV_DEPTH = i2cs_pkg::RECV_DEPTH,
    parameter int SEND_DEPTH = i2cs_pkg::SEND_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_shift_value,
    input  logic [3:0] i_load_index,
    input  logic [7:0] i_load_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_sda_drive,
    output logic [7:0] o_tx_byte,
    output logic [3:0] o_shift_bits,
    output logic       o_listen_overflow,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte,
    output logic       o_rx_done,
    output logic [4:0] o_rx_count,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic           cmd_valid;
    logic           cmd_pop;
    i2cs_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    i2cs_front #(
        .SEND_DEPTH (SEND_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_shift_value (i_shift_value),
        .i_load_index  (i_load_index),
        .i_load_data   (i_load_data),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    i2cs_back #(
        .RECV_DEPTH (RECV_DEPTH),
        .SEND_DEPTH (SEND_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sda_drive       (o_sda_drive),
        .o_tx_byte         (o_tx_byte),
        .o_shift_bits      (o_shift_bits),
        .o_listen_overflow (o_listen_overflow),
        .o_rx_valid        (o_rx_valid),
        .o_rx_byte         (o_rx_byte),
        .o_rx_done         (o_rx_done),
        .o_rx_count        (o_rx_count)
    );

endmodule

[dv/i2c_slave_byte_engine_tb.sv]
// ----------------------------------------------------------------------------
// i2c_slave_byte_engine_tb
// Self-checking bench for the I2C slave byte engine. A queue of bus events
// (directed, then random write/read frames with noise) feeds a clocked driver.
// Each accepted item is run through a local model of the sequencer and the
// predicted bus setup is queued; a clocked monitor checks every result
// field by field. Address and send length are changed between phases.
// ----------------------------------------------------------------------------
module i2c_slave_byte_engine_tb;

    localparam int WATCHDOG = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER = 300;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ADDR, ST_ACKED, ST_DATA, ST_ACK_CHECK, ST_SEND, ST_GET_ACK
    } t_seq_state;

    typedef struct packed {
        i2cs_pkg::t_func func;
        logic [7:0]      sv;
        logic [3:0]      li;
        logic [7:0]      ld;
    } t_bus_ev;

    typedef struct packed {
        logic       drive;
        logic [7:0] tx;
        logic [3:0] bits;
        logic       listen;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_done;
        logic [4:0] rx_count;
    } t_bus_setup;

    typedef struct {
        t_seq_state                           st;
        logic [4:0]                           recv_cnt;
        logic [4:0]                           send_idx;
        logic [i2cs_pkg::SEND_DEPTH-1:0][7:0] store;
        logic [7:0]                           own;
        logic [4:0]                           len;
        logic                                 drive;
        logic [7:0]                           tx;
        logic [3:0]                           bits;
        logic                                 listen;
        int                                   rd_idx;
    } t_engine;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_func = '0;
    logic [7:0] i_shift_value = '0;
    logic [3:0] i_load_index = '0;
    logic [7:0] i_load_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_sda_drive;
    logic [7:0] o_tx_byte;
    logic [3:0] o_shift_bits;
    logic       o_listen_overflow;
    logic       o_rx_valid;
    logic [7:0] o_rx_byte;
    logic       o_rx_done;
    logic [4:0] o_rx_count;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    i2c_slave_byte_engine dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_shift_value     (i_shift_value),
        .i_load_index      (i_load_index),
        .i_load_data       (i_load_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sda_drive       (o_sda_drive),
        .o_tx_byte         (o_tx_byte),
        .o_shift_bits      (o_shift_bits),
        .o_listen_overflow (o_listen_overflow),
        .o_rx_valid        (o_rx_valid),
        .o_rx_byte         (o_rx_byte),
        .o_rx_done         (o_rx_done),
        .o_rx_count        (o_rx_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_bus_ev    pend_q[$];
    t_bus_setup setup_q[$];
    t_engine    pred;
    t_engine    gen;
    logic [i2cs_pkg::SEND_DEPTH-1:0] loaded = '0;
    logic       in_acc = 1'b0;
    logic       cfg_acc = 1'b0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    int         n_results = 0;
    int         n_bad = 0;
    int         n_gen = 0;
    int         quiet_cycles = 0;
    int         hold_cnt = 0;
    logic       hold_done = 1'b0;

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------
    function automatic t_engine engine_init();
        t_engine e;
        e.st = ST_IDLE;
        e.recv_cnt = '0;
        e.send_idx = '0;
        e.store = '0;
        e.own = '0;
        e.len = '0;
        e.drive = 1'b0;
        e.tx = '0;
        e.bits = '0;
        e.listen = 1'b0;
        e.rd_idx = -1;
        return e;
    endfunction

    function automatic void set_bus(inout t_engine e, input logic d, input logic [7:0] t,
                                    input logic [3:0] b, input logic l);
        e.drive = d;
        e.tx = t;
        e.bits = b;
        e.listen = l;
    endfunction

    function automatic void go_idle(inout t_engine e);
        e.st = ST_IDLE;
        set_bus(e, 1'b0, 8'h00, 4'd0, 1'b0);
    endfunction

    function automatic void send_next(inout t_engine e);
        int lim;
        logic [7:0] b;
        lim = (e.len < i2cs_pkg::SEND_DEPTH) ? int'(e.len) : i2cs_pkg::SEND_DEPTH;
        if (int'(e.send_idx) < lim) begin
            e.rd_idx = int'(e.send_idx);
            b = e.store[e.send_idx[3:0]];
            e.send_idx = e.send_idx + 5'd1;
            set_bus(e, 1'b1, b, 4'd8, 1'b1);
            e.st = ST_GET_ACK;
        end else begin
            go_idle(e);
        end
    endfunction

    function automatic t_bus_setup bus_step(inout t_engine e, input t_bus_ev ev);
        t_bus_setup r;
        r = '0;
        e.rd_idx = -1;
        case (ev.func)
            i2cs_pkg::FUNC_START: begin
                // restarts the sequencer from any state
                e.st = ST_ADDR;
                set_bus(e, 1'b0, 8'h00, 4'd8, 1'b1);
            end
            i2cs_pkg::FUNC_STOP: begin
                if (e.st == ST_DATA) begin
                    r.rx_done = 1'b1;
                    r.rx_count = e.recv_cnt;
                    go_idle(e);
                end
            end
            i2cs_pkg::FUNC_LOAD: begin
                e.store[ev.li] = ev.ld;
            end
            default: begin
                case (e.st)
                    ST_ADDR: begin
                        if ((ev.sv & i2cs_pkg::ADDR_MASK) == e.own) begin
                            set_bus(e, 1'b1, 8'h00, 4'd1, 1'b1);
                            if (ev.sv[0]) begin
                                e.send_idx = '0;
                                e.st = ST_SEND;
                            end else begin
                                e.recv_cnt = '0;
                                e.st = ST_ACKED;
                            end
                        end else begin
                            go_idle(e);
                        end
                    end
                    ST_ACKED: begin
                        set_bus(e, 1'b0, 8'h00, 4'd8, 1'b1);
                        e.st = ST_DATA;
                    end
                    ST_DATA: begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = ev.sv;
                        e.recv_cnt = e.recv_cnt + 5'd1;
                        if (int'(e.recv_cnt) < i2cs_pkg::RECV_DEPTH) begin
                            set_bus(e, 1'b1, 8'h00, 4'd1, 1'b1);
                            e.st = ST_ACKED;
                        end else begin
                            r.rx_done = 1'b1;
                            r.rx_count = e.recv_cnt;
                            go_idle(e);
                        end
                    end
                    ST_ACK_CHECK: begin
                        // any nonzero sample is a master NACK
                        if (ev.sv != 8'h00)
                            go_idle(e);
                        else
                            send_next(e);
                    end
                    ST_SEND: send_next(e);
                    ST_GET_ACK: begin
                        set_bus(e, 1'b0, 8'h00, 4'd1, 1'b1);
                        e.st = ST_ACK_CHECK;
                    end
                    default: ;
                endcase
            end
        endcase
        r.drive = e.drive;
        r.tx = e.tx;
        r.bits = e.bits;
        r.listen = e.listen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic flag_bad(input string what);
        n_bad++;
        if (n_bad <= 10)
            $display("MISMATCH: %s", what);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
            flag_bad($sformatf("result %0d %s: expected %0h, got %0h",
                               n_results, name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_bus_setup want;
        logic       moved;
        moved = 1'b0;
        in_acc <= i_rst_n && i_in_valid && !o_in_stall;
        cfg_acc <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    i2cs_pkg::CFG_OWN_ADDR: pred.own = i_cfg_data;
                    i2cs_pkg::CFG_SEND_LEN: pred.len = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                setup_q.push_back(bus_step(pred, '{i2cs_pkg::t_func'(i_func),
                                                   i_shift_value, i_load_index,
                                                   i_load_data}));
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (setup_q.size() == 0) begin
                    flag_bad($sformatf("result %0d arrived with nothing expected",
                                       n_results));
                end else begin
                    want = setup_q.pop_front();
                    check_field("sda_drive", 8'(want.drive), 8'(o_sda_drive));
                    check_field("tx_byte", want.tx, o_tx_byte);
                    check_field("shift_bits", 8'(want.bits), 8'(o_shift_bits));
                    check_field("listen_overflow", 8'(want.listen), 8'(o_listen_overflow));
                    check_field("rx_valid", 8'(want.rx_valid), 8'(o_rx_valid));
                    check_field("rx_byte", want.rx_byte, o_rx_byte);
                    check_field("rx_done", 8'(want.rx_done), 8'(o_rx_done));
                    check_field("rx_count", 8'(want.rx_count), 8'(o_rx_count));
                end
                n_results <= n_results + 1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver and receiver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_bus_ev ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (in_acc || !i_in_valid) begin
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                ev = pend_q.pop_front();
                i_func <= ev.func;
                i_shift_value <= ev.sv;
                i_load_index <= ev.li;
                i_load_data <= ev.ld;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            // long hold-off so the event queue fills and the input stalls
            i_out_stall <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // A look-ahead copy of the model spots sends from unloaded entries and
    // loads the entry just in front of the event that would read it.
    task automatic push_event(input t_bus_ev ev);
        t_engine trial;
        t_bus_ev fill;
        trial = gen;
        void'(bus_step(trial, ev));
        if (trial.rd_idx >= 0 && !loaded[trial.rd_idx]) begin
            fill = '{i2cs_pkg::FUNC_LOAD, 8'($urandom), 4'(trial.rd_idx), 8'($urandom)};
            loaded[trial.rd_idx] = 1'b1;
            void'(bus_step(gen, fill));
            pend_q.push_back(fill);
        end
        void'(bus_step(gen, ev));
        if (ev.func == i2cs_pkg::FUNC_LOAD)
            loaded[ev.li] = 1'b1;
        else
            n_gen++;
        pend_q.push_back(ev);
    endtask

    task automatic shift_ev(input logic [7:0] v);
        push_event('{i2cs_pkg::FUNC_SHIFT, v, 4'($urandom), 8'($urandom)});
    endtask

    task automatic bus_ev(input i2cs_pkg::t_func f);
        push_event('{f, 8'($urandom), 4'($urandom), 8'($urandom)});
    endtask

    task automatic load_ev(input logic [3:0] idx, input logic [7:0] d);
        push_event('{i2cs_pkg::FUNC_LOAD, 8'($urandom), idx, d});
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!cfg_acc);
        i_cfg_valid <= 1'b0;
        if (idx == i2cs_pkg::CFG_OWN_ADDR)
            gen.own = val;
        else
            gen.len = val[4:0];
    endtask

    task automatic drain();
        do @(negedge i_clk); while (pend_q.size() != 0 || i_in_valid || setup_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_frames(input int n);
        int target;
        int pick;
        int k;
        target = n_gen + n;
        while (n_gen < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // master write, sometimes to a foreign address
                bus_ev(i2cs_pkg::FUNC_START);
                shift_ev(($urandom_range(0, 9) == 0) ? 8'($urandom) : {gen.own[7:1], 1'b0});
                k = $urandom_range(0, 18);
                for (int j = 0; j < k; j++) begin
                    shift_ev(8'($urandom));
                    shift_ev(8'($urandom));
                end
                if ($urandom_range(0, 9) < 2)
                    shift_ev(8'($urandom));
                if ($urandom_range(0, 9) < 7)
                    bus_ev(i2cs_pkg::FUNC_STOP);
            end else if (pick < 75) begin
                // master read, mostly ACKed, runs past the send length at times
                bus_ev(i2cs_pkg::FUNC_START);
                shift_ev(($urandom_range(0, 9) == 0) ? 8'($urandom) : {gen.own[7:1], 1'b1});
                shift_ev(8'($urandom));
                k = $urandom_range(0, 17);
                for (int j = 0; j < k; j++) begin
                    shift_ev(8'($urandom));
                    shift_ev(($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)));
                end
                bus_ev(i2cs_pkg::FUNC_STOP);
            end else if (pick < 85) begin
                k = $urandom_range(1, 3);
                for (int j = 0; j < k; j++)
                    load_ev(4'($urandom), 8'($urandom));
            end else begin
                k = $urandom_range(1, 4);
                for (int j = 0; j < k; j++)
                    push_event('{i2cs_pkg::t_func'($urandom_range(0, 3)), 8'($urandom),
                                 4'($urandom), 8'($urandom)});
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] own, input logic [4:0] len, input int n);
        write_reg(i2cs_pkg::CFG_OWN_ADDR, own);
        write_reg(i2cs_pkg::CFG_SEND_LEN, {3'b000, len});
        random_frames(n);
        drain();
    endtask

    initial begin
        pred = engine_init();
        gen = engine_init();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 19;
        rcv_idle_pct = 56;

        // directed: ignored events, write frame, read frame, mismatch, restart
        write_reg(i2cs_pkg::CFG_OWN_ADDR, 8'h5a);
        write_reg(i2cs_pkg::CFG_SEND_LEN, 8'd3);
        shift_ev(8'hff);
        bus_ev(i2cs_pkg::FUNC_STOP);
        load_ev(4'd0, 8'h00);
        load_ev(4'd15, 8'hff);
        bus_ev(i2cs_pkg::FUNC_START);
        shift_ev(8'h5a);
        shift_ev(8'h00);
        shift_ev(8'hff);
        shift_ev(8'hff);
        shift_ev(8'h00);
        bus_ev(i2cs_pkg::FUNC_STOP);
        bus_ev(i2cs_pkg::FUNC_START);
        shift_ev(8'h5b);
        shift_ev(8'h00);
        shift_ev(8'h00);
        shift_ev(8'h00);
        shift_ev(8'h00);
        shift_ev(8'h80);
        bus_ev(i2cs_pkg::FUNC_START);
        shift_ev(8'h20);
        bus_ev(i2cs_pkg::FUNC_START);
        shift_ev(8'h5a);
        bus_ev(i2cs_pkg::FUNC_START);
        bus_ev(i2cs_pkg::FUNC_STOP);
        drain();

        run_phase(8'hfe, 5'd16, 350);

        snd_idle_pct = 56;
        rcv_idle_pct = 19;
        run_phase(8'h00, 5'd31, 250);
        run_phase(8'h55, 5'd0, 100);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(8'ha4, 5'd1, 150);
        run_phase({7'($urandom), 1'b0}, 5'($urandom_range(0, 20)), 150);

        if (setup_q.size() != 0)
            flag_bad($sformatf("%0d expected results never arrived", setup_q.size()));
        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/i2cs_pkg.sv
rtl/core/i2cs_ram.sv
rtl/core/i2cs_front.sv
rtl/core/i2cs_back.sv
rtl/core/i2c_slave_byte_engine.sv
dv/i2c_slave_byte_engine_tb.sv
